### rtl/core/hmgbs_pkg.sv
// Shared types, constants and helpers of the height map gray box smoothing unit.
package hmgbs_pkg;

    // Image size limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;

    // Pixel and sum widths: a pixel sum is at most 765, a column of three at
    // most 2295 and the full window of nine at most 6885.
    localparam int CHAN_W   = 8;
    localparam int SUM_W    = 10;
    localparam int COLSUM_W = 12;
    localparam int TOTAL_W  = 13;
    localparam int HEIGHT_W = 16;

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = 3 * CHAN_W;
    localparam int M_FIELD_W = HEIGHT_W + ROW_W + COL_W;
    localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Reciprocal constants. Interior: floor(t*256/27) = (t*K)>>18 for t <= 6885.
    // Border: floor(s*256/3) = (s*K)>>18 for s <= 765, with the border constant
    // scaled by 64 so that both share one shift.
    localparam int RECIP_W        = 25;
    localparam int PRODUCT_W      = TOTAL_W + RECIP_W;
    localparam int RECIP_SHIFT    = 18;
    localparam logic [RECIP_W-1:0] RECIP_INTERIOR = 25'd2485514;
    localparam logic [RECIP_W-1:0] RECIP_BORDER   = 25'd22369664;

    // One classified pixel as it waits in the queue.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TOTAL_W-1:0] total;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               emit_interior;
        logic               emit_border;
    } item_t;

    // Clamp a size register to 3..hi and return the index of its last element.
    function automatic logic [SIZE_W-1:0] size_last(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] clamped;
        clamped = v;
        if (v < SIZE_W'(3)) begin
            clamped = SIZE_W'(3);
        end else if (v > hi) begin
            clamped = hi;
        end
        return clamped - SIZE_W'(1);
    endfunction

endpackage

### rtl/core/hmgbs_front.sv
// Front end: accepts pixels, keeps position and line buffers, builds window sums.
module hmgbs_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hmgbs_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                cfg_wr_en,
    input  logic [hmgbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmgbs_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic [hmgbs_pkg::LEVEL_W-1:0]       queue_level,
    output logic                                push,
    output hmgbs_pkg::item_t                    push_item
);

    logic                              accept;
    logic [hmgbs_pkg::SUM_W-1:0]       pixel_sum;
    logic                              at_last_col;
    logic                              at_last_row;

    logic [hmgbs_pkg::COL_W-1:0]       width_last_reg;
    logic [hmgbs_pkg::ROW_W-1:0]       height_last_reg;
    logic [hmgbs_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [hmgbs_pkg::COL_W-1:0]       col_reg, col_next;

    logic                              valid1_reg;
    logic [hmgbs_pkg::SUM_W-1:0]       sum1_reg;
    logic [hmgbs_pkg::ROW_W-1:0]       row1_reg;
    logic [hmgbs_pkg::COL_W-1:0]       col1_reg;
    logic                              emit_int1_reg;
    logic                              emit_brd1_reg;

    logic [hmgbs_pkg::SUM_W-1:0]       line_older_mem [hmgbs_pkg::MAX_WIDTH];
    logic [hmgbs_pkg::SUM_W-1:0]       line_newer_mem [hmgbs_pkg::MAX_WIDTH];
    logic [hmgbs_pkg::SUM_W-1:0]       older_rd_reg;
    logic [hmgbs_pkg::SUM_W-1:0]       newer_rd_reg;

    logic [hmgbs_pkg::COLSUM_W-1:0]    colsum_m1_reg;
    logic [hmgbs_pkg::COLSUM_W-1:0]    colsum_m2_reg;
    logic [hmgbs_pkg::COLSUM_W-1:0]    colsum_now;
    logic [hmgbs_pkg::TOTAL_W-1:0]     window_total;

    // Take a word only when the queue has room for it and the one in flight.
    assign s_tready = aresetn
                      && (({1'b0, queue_level} + (hmgbs_pkg::LEVEL_W + 1)'(valid1_reg))
                          < (hmgbs_pkg::LEVEL_W + 1)'(hmgbs_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    assign pixel_sum = hmgbs_pkg::SUM_W'(s_tdata[7:0])
                     + hmgbs_pkg::SUM_W'(s_tdata[15:8])
                     + hmgbs_pkg::SUM_W'(s_tdata[23:16]);

    assign at_last_col = (col_reg == width_last_reg);
    assign at_last_row = (row_reg == height_last_reg);

    // Raster position of the next pixel, wrapping at the end of a row and image.
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + hmgbs_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + hmgbs_pkg::COL_W'(1);
            end
        end
    end

    // Size registers and position; any size write restarts the image.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= hmgbs_pkg::COL_W'(255);
            height_last_reg <= hmgbs_pkg::ROW_W'(255);
            row_reg         <= '0;
            col_reg         <= '0;
        end else if (cfg_wr_en) begin
            unique case (hmgbs_pkg::cfg_reg_t'(cfg_index))
                hmgbs_pkg::REG_IMAGE_WIDTH: begin
                    width_last_reg <= hmgbs_pkg::COL_W'(hmgbs_pkg::size_last(cfg_wdata,
                        hmgbs_pkg::SIZE_W'(hmgbs_pkg::MAX_WIDTH)));
                end
                hmgbs_pkg::REG_IMAGE_HEIGHT: begin
                    height_last_reg <= hmgbs_pkg::ROW_W'(hmgbs_pkg::size_last(cfg_wdata,
                        hmgbs_pkg::SIZE_W'(hmgbs_pkg::MAX_HEIGHT)));
                end
                default: begin
                end
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Stage one control: one item in flight between accept and queue push.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else begin
            valid1_reg <= accept;
        end
    end

    // Stage one payload and classification of the accepted pixel.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sum1_reg      <= pixel_sum;
            row1_reg      <= row_reg;
            col1_reg      <= col_reg;
            emit_int1_reg <= (row_reg >= hmgbs_pkg::ROW_W'(2))
                          && (col_reg >= hmgbs_pkg::COL_W'(2));
            emit_brd1_reg <= (row_reg == '0) || at_last_row
                          || (col_reg == '0) || at_last_col;
        end
    end

    // Line buffers: read the column on accept, shift the column by one row from stage one.
    always_ff @(posedge aclk) begin
        if (accept) begin
            older_rd_reg <= line_older_mem[col_reg];
            newer_rd_reg <= line_newer_mem[col_reg];
        end
        if (valid1_reg) begin
            line_older_mem[col1_reg] <= newer_rd_reg;
            line_newer_mem[col1_reg] <= sum1_reg;
        end
    end

    // Column sums of the two previous columns of the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colsum_m1_reg <= '0;
            colsum_m2_reg <= '0;
        end else if (valid1_reg) begin
            colsum_m1_reg <= colsum_now;
            colsum_m2_reg <= colsum_m1_reg;
        end
    end

    assign colsum_now   = hmgbs_pkg::COLSUM_W'(older_rd_reg)
                        + hmgbs_pkg::COLSUM_W'(newer_rd_reg)
                        + hmgbs_pkg::COLSUM_W'(sum1_reg);
    assign window_total = hmgbs_pkg::TOTAL_W'(colsum_m1_reg)
                        + hmgbs_pkg::TOTAL_W'(colsum_m2_reg)
                        + hmgbs_pkg::TOTAL_W'(colsum_now);

    // Hand the classified item to the queue.
    assign push                    = valid1_reg;
    assign push_item.sum           = sum1_reg;
    assign push_item.total         = window_total;
    assign push_item.row           = row1_reg;
    assign push_item.col           = col1_reg;
    assign push_item.emit_interior = emit_int1_reg;
    assign push_item.emit_border   = emit_brd1_reg;

    // An item reaches stage one only from a word taken the cycle before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid1_reg |-> $past(accept))
        else $error("stage one valid without an accepted word");

endmodule

### rtl/core/hmgbs_queue.sv
// Short queue of classified items between the front and the back.
module hmgbs_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  hmgbs_pkg::item_t                    push_item,
    input  logic                                pop,
    output hmgbs_pkg::item_t                    head,
    output logic                                head_valid,
    output logic [hmgbs_pkg::LEVEL_W-1:0]       level
);

    hmgbs_pkg::item_t                  entries [hmgbs_pkg::QUEUE_DEPTH];
    logic [hmgbs_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [hmgbs_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [hmgbs_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic                              do_pop;

    assign do_pop     = pop && (level_reg != '0);
    assign head       = entries[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + hmgbs_pkg::PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + hmgbs_pkg::PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !do_pop) begin
            level_next = level_reg + hmgbs_pkg::LEVEL_W'(1);
        end else if (!push && do_pop) begin
            level_next = level_reg - hmgbs_pkg::LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    // The front's credit check must keep the queue from overflowing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (level_reg != hmgbs_pkg::LEVEL_W'(hmgbs_pkg::QUEUE_DEPTH)) || pop)
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= hmgbs_pkg::LEVEL_W'(hmgbs_pkg::QUEUE_DEPTH))
        else $error("queue level beyond its depth");

endmodule

### rtl/core/hmgbs_back.sv
// Back end: turns queued items into zero, one or two result words through a reciprocal multiply.
module hmgbs_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hmgbs_pkg::item_t                    head,
    input  logic                                head_valid,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hmgbs_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    logic                                  phase_reg, phase_next;
    logic                                  cur_interior;
    logic                                  has_result;
    logic                                  out_free;
    logic                                  load;
    logic                                  last;
    logic [hmgbs_pkg::TOTAL_W-1:0]         mult_a;
    logic [hmgbs_pkg::RECIP_W-1:0]         mult_k;
    logic [hmgbs_pkg::PRODUCT_W-1:0]       product;
    logic [hmgbs_pkg::ROW_W-1:0]           row_out;
    logic [hmgbs_pkg::COL_W-1:0]           col_out;

    logic                                  m_valid_reg, m_valid_next;
    logic [hmgbs_pkg::HEIGHT_W-1:0]        height_reg;
    logic [hmgbs_pkg::ROW_W-1:0]           row_reg;
    logic [hmgbs_pkg::COL_W-1:0]           col_reg;
    logic                                  last_reg;

    // The interior result of an item goes out before its border result.
    assign cur_interior = head.emit_interior && !phase_reg;
    assign has_result   = head_valid && (cur_interior || head.emit_border);
    assign out_free     = !m_valid_reg || m_tready;
    assign load         = has_result && out_free;
    assign last         = !(cur_interior && head.emit_border);
    assign pop          = head_valid
                       && (!(cur_interior || head.emit_border) || (load && last));

    always_comb begin
        phase_next = phase_reg;
        if (pop) begin
            phase_next = 1'b0;
        end else if (load && cur_interior) begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // One shared multiplier: window total by 256/27 or pixel sum by 256/3.
    assign mult_a  = cur_interior ? head.total : hmgbs_pkg::TOTAL_W'(head.sum);
    assign mult_k  = cur_interior ? hmgbs_pkg::RECIP_INTERIOR : hmgbs_pkg::RECIP_BORDER;
    assign product = hmgbs_pkg::PRODUCT_W'(mult_a) * hmgbs_pkg::PRODUCT_W'(mult_k);

    // An interior result names the centre pixel, one up and one left.
    assign row_out = cur_interior ? head.row - hmgbs_pkg::ROW_W'(1) : head.row;
    assign col_out = cur_interior ? head.col - hmgbs_pkg::COL_W'(1) : head.col;

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            height_reg <= product[hmgbs_pkg::RECIP_SHIFT +: hmgbs_pkg::HEIGHT_W];
            row_reg    <= row_out;
            col_reg    <= col_out;
            last_reg   <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(hmgbs_pkg::M_DATA_W - hmgbs_pkg::M_FIELD_W)'(0),
                       col_reg, row_reg, height_reg};

    // The second phase only exists for items with both results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid && head.emit_interior && head.emit_border)
        else $error("border phase without a two-result item");

endmodule

### rtl/core/height_map_gray_box_smoothing_unit.sv
// Top level of the height map gray box smoothing unit: front, queue and back.
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   tdata: red, green, blue
//  m_        out        m_tvalid/m_tready   tdata: height_q8, row, column; tlast: last_of_run
//  cfg_      in         cfg_wr_en           index 0 image_width, 1 image_height
//
//  A pixel word can be taken every cycle while the queue has room; it passes through
//  the stage one registers into the queue, and its first result is then registered on
//  the output through a single multiplier.
//  The output port carries one result per cycle while m_tready is high, so two-result
//  pixels limit the sustained rate to the output side, with a four-entry queue in between.
//  aresetn is synchronous and active low; sizes return to 256 by 256.
//  Line buffers hold no reset state and need no clearing pass.
module height_map_gray_box_smoothing_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hmgbs_pkg::S_DATA_W-1:0]      s_tdata,   // red, green, blue
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hmgbs_pkg::M_DATA_W-1:0]      m_tdata,   // height_q8, row, column
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [hmgbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmgbs_pkg::SIZE_W-1:0]        cfg_wdata
);

    logic                              push;
    hmgbs_pkg::item_t                  push_item;
    logic                              pop;
    hmgbs_pkg::item_t                  head;
    logic                              head_valid;
    logic [hmgbs_pkg::LEVEL_W-1:0]     level;

    // Pixel intake, position tracking and window sums.
    hmgbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .queue_level (level),
        .push        (push),
        .push_item   (push_item)
    );

    // Decoupling queue.
    hmgbs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .level      (level)
    );

    // Result generation and output register.
    hmgbs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
